@@ rtl/tld_pkg.sv @@
// Shared types, codes and constants of the terminal line discipline.
`timescale 1ns / 1ps

package tld_pkg;

	localparam int LINE_CAP_DEF  = 32;
	localparam int TAB_WIDTH_DEF = 8;
	localparam int ADDR_MAX_W    = 8;

	// Configuration register indexes.
	localparam logic [2:0] CFG_INPUT_FLAGS  = 3'd0;
	localparam logic [2:0] CFG_LOCAL_FLAGS  = 3'd1;
	localparam logic [2:0] CFG_OUTPUT_FLAGS = 3'd2;
	localparam logic [2:0] CFG_SIGNAL_CHARS = 3'd3;
	localparam logic [2:0] CFG_EDIT_CHARS   = 3'd4;

	localparam logic [2:0]  IFLAGS_RST = 3'd2;
	localparam logic [6:0]  LFLAGS_RST = 7'd47;
	localparam logic [2:0]  OFLAGS_RST = 3'd3;
	localparam logic [23:0] SIGCH_RST  = 24'd1711107;
	localparam logic [31:0] EDITCH_RST = 32'd218371336;

	// Request types.
	localparam logic [1:0] REQ_RX    = 2'd0;
	localparam logic [1:0] REQ_TX    = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	// Result kinds.
	localparam logic [2:0] KIND_ECHO  = 3'd0;
	localparam logic [2:0] KIND_ERASE = 3'd1;
	localparam logic [2:0] KIND_LINE  = 3'd2;
	localparam logic [2:0] KIND_LEND  = 3'd3;
	localparam logic [2:0] KIND_RAW   = 3'd4;
	localparam logic [2:0] KIND_SIG   = 3'd5;
	localparam logic [2:0] KIND_TX    = 3'd6;

	localparam logic [1:0] SIG_INTR = 2'd0;
	localparam logic [1:0] SIG_QUIT = 2'd1;
	localparam logic [1:0] SIG_SUSP = 2'd2;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  byte_val;
		logic [15:0] rep;
		logic [1:0]  sig;
		logic [4:0]  len;
		logic        eof;
	} res_t;

	typedef struct packed {
		logic                  re;
		logic [ADDR_MAX_W-1:0] raddr;
		logic                  we;
		logic [ADDR_MAX_W-1:0] waddr;
		logic [7:0]            wdata;
	} mem_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISP,
		ST_ECHO,
		ST_ECHO2,
		ST_KNL,
		ST_RAW,
		ST_TX2,
		ST_STORE,
		ST_DLV_START,
		ST_DLV,
		ST_DLV_END,
		ST_ERASE,
		ST_TABW_START,
		ST_TABW,
		ST_TABW_END,
		ST_KILL,
		ST_FIN
	} st_t;

	typedef enum logic [1:0] {
		CONT_DONE,
		CONT_KNL,
		CONT_RAW,
		CONT_STORE
	} cont_t;

	function automatic logic is_ctrl(input logic [7:0] b);
		return (b < CH_SP) || (b == CH_DEL);
	endfunction

	function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] b,
			input logic [15:0] rep, input logic [1:0] sig, input logic [4:0] len,
			input logic eof);
		res_t r;
		r.kind     = kind;
		r.byte_val = b;
		r.rep      = rep;
		r.sig      = sig;
		r.len      = len;
		r.eof      = eof;
		return r;
	endfunction

endpackage

@@ rtl/tld_line_mem.sv @@
// Line store: single write port, one registered read port.
`timescale 1ns / 1ps

module tld_line_mem import tld_pkg::*; #(
	parameter int LINE_CAP = LINE_CAP_DEF
) (
	input  logic       clk,
	input  mem_req_t   req,
	output logic [7:0] rdata
);

	localparam int AW = $clog2(LINE_CAP);

	logic [7:0] mem [LINE_CAP];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr[AW-1:0]];
		end
	end

endmodule

@@ rtl/tty_line_discipline_core.sv @@
// Top level of the terminal line discipline: sequencer, column tracking, result staging.
`timescale 1ns / 1ps

// Usage. Items enter on the s_ channel: s_tuser is the request type (received byte,
// byte to transmit, flush), s_tdata the byte. Results leave on the m_ channel with the
// kind on m_tuser and m_tlast on the final result of an item. The cfg channel writes
// the five registers; it is always ready and should only be used while the block idles.
// One item is worked on at a time; s_tready is high only while the sequencer is idle.
// A signal or a plain transmit item yields a single result; an inserted CR is sent
// before the newline. A received byte that is echoed is echoed before it is stored or
// passed on, with a caret first for caret notation. Delivering a line reads the line
// store one entry per cycle while the receiver does not stall. An erased tab walks the
// remaining entries to recompute the column, and an echoed kill repeats an erase for
// each stored byte; the single read port of the line store serialises these reads.
// Results pass through a staging register and an output register. A staged result moves
// on to the output register when the next result is produced or the item finishes, so it
// waits longer while a line walk is running.
// When the receiver stalls, the sequencer holds in place until the output register
// frees up; nothing is dropped.
// Reset clears the registers to their defaults, the line count and the column to zero.
// The line store contents are not cleared; only entries below the line count are read.
module tty_line_discipline_core import tld_pkg::*; #(
	parameter int LINE_CAP  = LINE_CAP_DEF,
	parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_byte[7:0], repeat_count[23:8], signal_code[25:24],
	                               // line_length[30:26], end_of_file[31]
	output logic [2:0]  m_tuser,   // kind[2:0]
	output logic        m_tlast,
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW      = $clog2(LINE_CAP);
	localparam int MW      = $clog2(TAB_WIDTH);
	localparam int DW      = $clog2(TAB_WIDTH + 1);
	localparam int SW      = DW + 1;
	localparam int SAT_MOD = 65535 % TAB_WIDTH;

	// Column arithmetic. The column modulo the tab width is tracked alongside the column.
	function automatic logic [15+MW:0] col_add(input logic [15:0] col,
			input logic [MW-1:0] md, input logic [DW-1:0] d);
		logic [16:0]   sum;
		logic [SW-1:0] ms;
		sum = {1'b0, col} + 17'(d);
		ms  = SW'(md) + SW'(d);
		if (sum > 17'd65535) begin
			return {16'hFFFF, MW'(SAT_MOD)};
		end else if (ms >= SW'(TAB_WIDTH)) begin
			return {sum[15:0], MW'(ms - SW'(TAB_WIDTH))};
		end else begin
			return {sum[15:0], MW'(ms)};
		end
	endfunction

	function automatic logic [15+MW:0] col_sub(input logic [15:0] col,
			input logic [MW-1:0] md, input logic [1:0] w);
		logic [SW-1:0] mw;
		mw = SW'(md);
		if (col >= 16'(w)) begin
			if (mw >= SW'(w)) begin
				return {col - 16'(w), MW'(mw - SW'(w))};
			end else begin
				return {col - 16'(w), MW'(mw + SW'(TAB_WIDTH) - SW'(w))};
			end
		end else begin
			return '0;
		end
	endfunction

	// Configuration registers.
	logic [2:0]  iflags_q;
	logic [6:0]  lflags_q;
	logic [2:0]  oflags_q;
	logic [23:0] sigch_q;
	logic [31:0] editch_q;

	// Sequencer state.
	st_t             state_q, state_d;
	logic [1:0]      req_q;
	logic [7:0]      c_q;
	logic            ign_q;
	logic [7:0]      echo_c_q, echo_c_d;
	cont_t           cont_q, cont_d;
	logic            kill_q, kill_d;
	logic            eof_q, eof_d;
	logic [CW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   count_q, count_d;
	logic [15:0]     col_q, col_d;
	logic [MW-1:0]   mod_q, mod_d;
	logic [15:0]     nc_q, nc_d;
	logic [MW-1:0]   ncm_q, ncm_d;

	// Result staging and output register.
	logic            pend_v_q;
	res_t            pend_q;
	logic            out_v_q;
	res_t            out_q;
	logic            out_last_q;

	logic            emit_v;
	res_t            emit_r;
	mem_req_t        mreq;
	logic [7:0]      rdata;
	logic            out_free, fin_push, need_out, stall;

	// Input byte mapping at acceptance.
	logic [7:0]      map_c;
	logic            map_ign;

	tld_line_mem #(.LINE_CAP(LINE_CAP)) u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_v_q;
	assign m_tuser   = out_q.kind;
	assign m_tlast   = out_last_q;
	assign m_tdata   = {out_q.eof, out_q.len, out_q.sig, out_q.rep, out_q.byte_val};

	assign out_free = !out_v_q || m_tready;
	assign fin_push = (state_q == ST_FIN) && pend_v_q;
	assign need_out = (emit_v && pend_v_q) || fin_push;
	assign stall    = need_out && !out_free;

	always_comb begin
		map_c   = s_tdata;
		map_ign = 1'b0;
		if (s_tuser == REQ_RX) begin
			if (s_tdata == CH_CR) begin
				if (iflags_q[0]) begin
					map_ign = 1'b1;
				end else if (iflags_q[1]) begin
					map_c = CH_NL;
				end
			end else if (s_tdata == CH_NL && iflags_q[2]) begin
				map_c = CH_CR;
			end
		end
	end

	// Character roles, checked in priority order.
	logic [7:0] erase_c, kill_c, eof_c, eol_c;
	logic       is_intr, is_quit, is_susp, is_erase, is_kill, is_eofc, is_lend;
	assign erase_c  = editch_q[7:0];
	assign kill_c   = editch_q[15:8];
	assign eof_c    = editch_q[23:16];
	assign eol_c    = editch_q[31:24];
	assign is_intr  = lflags_q[0] && (c_q == sigch_q[7:0]);
	assign is_quit  = lflags_q[0] && !is_intr && (c_q == sigch_q[15:8]);
	assign is_susp  = lflags_q[0] && !is_intr && !is_quit && (c_q == sigch_q[23:16]);
	assign is_erase = (c_q == erase_c);
	assign is_kill  = !is_erase && (c_q == kill_c);
	assign is_eofc  = !is_erase && !is_kill && (c_q == eof_c);
	assign is_lend  = (c_q == CH_NL) || (c_q == eol_c);

	// Echo character classes. New line, carriage return, tab and backspace have their own echo even
	// though they are control characters.
	logic e_nl, e_tab, e_bs, e_caret;
	assign e_nl    = (echo_c_q == CH_NL) || (echo_c_q == CH_CR);
	assign e_tab   = (echo_c_q == CH_TAB);
	assign e_bs    = (echo_c_q == CH_BS);
	assign e_caret = is_ctrl(echo_c_q) && lflags_q[3] && !e_nl && !e_tab && !e_bs;

	logic tx_crnl;
	assign tx_crnl = (oflags_q[1:0] == 2'b11) && (c_q == CH_NL);

	logic [1:0] erase_w;
	assign erase_w = is_ctrl(rdata) ? (lflags_q[3] ? 2'd2 : 2'd0) : 2'd1;

	logic idx_end;
	assign idx_end = (idx_q == count_q - CW'(1));

	function automatic st_t cont_state(input cont_t cnt);
		unique case (cnt)
			CONT_DONE:  return ST_FIN;
			CONT_KNL:   return ST_KNL;
			CONT_RAW:   return ST_RAW;
			CONT_STORE: return ST_STORE;
			default:    return ST_FIN;
		endcase
	endfunction

	// Next state.
	always_comb begin
		state_d = state_q;
		if (!stall) begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_d = ST_DISP;
				end
				ST_DISP: begin
					unique case (req_q)
						REQ_TX: state_d = tx_crnl ? ST_TX2 : ST_FIN;
						REQ_RX: begin
							priority if (ign_q || is_intr || is_quit || is_susp) begin
								state_d = ST_FIN;
							end else if (lflags_q[1]) begin
								priority if (is_erase) begin
									state_d = (count_q != '0 && lflags_q[2]) ? ST_ERASE
									                                         : ST_FIN;
								end else if (is_kill) begin
									priority if (!lflags_q[2]) state_d = ST_FIN;
									else if (lflags_q[5]) state_d = ST_KILL;
									else state_d = ST_ECHO;
								end else if (is_eofc) begin
									state_d = ST_DLV_START;
								end else begin
									state_d = lflags_q[2] ? ST_ECHO : ST_STORE;
								end
							end else begin
								state_d = lflags_q[2] ? ST_ECHO : ST_RAW;
							end
						end
						default: state_d = ST_FIN;
					endcase
				end
				ST_ECHO:       state_d = e_caret ? ST_ECHO2 : cont_state(cont_q);
				ST_ECHO2:      state_d = cont_state(cont_q);
				ST_KNL:        state_d = ST_FIN;
				ST_RAW:        state_d = ST_FIN;
				ST_TX2:        state_d = ST_FIN;
				ST_STORE:      state_d = is_lend ? ST_DLV_START : ST_FIN;
				ST_DLV_START:  state_d = (count_q != '0) ? ST_DLV : ST_DLV_END;
				ST_DLV:        state_d = idx_end ? ST_DLV_END : ST_DLV;
				ST_DLV_END:    state_d = ST_FIN;
				ST_ERASE: begin
					priority if (rdata == CH_TAB) state_d = ST_TABW_START;
					else state_d = kill_q ? ST_KILL : ST_FIN;
				end
				ST_TABW_START: state_d = (count_q != '0) ? ST_TABW : ST_TABW_END;
				ST_TABW:       state_d = idx_end ? ST_TABW_END : ST_TABW;
				ST_TABW_END:   state_d = kill_q ? ST_KILL : ST_FIN;
				ST_KILL:       state_d = (count_q == '0) ? ST_FIN : ST_ERASE;
				ST_FIN:        state_d = ST_IDLE;
				default:       state_d = ST_IDLE;
			endcase
		end
	end

	// Datapath actions of each state.
	always_comb begin
		emit_v   = 1'b0;
		emit_r   = '0;
		mreq     = '0;
		echo_c_d = echo_c_q;
		cont_d   = cont_q;
		kill_d   = kill_q;
		eof_d    = eof_q;
		idx_d    = idx_q;
		count_d  = count_q;
		col_d    = col_q;
		mod_d    = mod_q;
		nc_d     = nc_q;
		ncm_d    = ncm_q;
		unique case (state_q)
			ST_DISP: begin
				unique case (req_q)
					REQ_TX: begin
						emit_v = 1'b1;
						emit_r = mk_res(KIND_TX, tx_crnl ? CH_CR : c_q, '0, '0, '0, 1'b0);
					end
					REQ_FLUSH: count_d = '0;
					REQ_RX: begin
						priority if (ign_q) begin
						end else if (is_intr) begin
							emit_v = 1'b1;
							emit_r = mk_res(KIND_SIG, '0, '0, SIG_INTR, '0, 1'b0);
							if (!lflags_q[6]) count_d = '0;
						end else if (is_quit) begin
							emit_v = 1'b1;
							emit_r = mk_res(KIND_SIG, '0, '0, SIG_QUIT, '0, 1'b0);
						end else if (is_susp) begin
							emit_v = 1'b1;
							emit_r = mk_res(KIND_SIG, '0, '0, SIG_SUSP, '0, 1'b0);
						end else if (lflags_q[1]) begin
							priority if (is_erase) begin
								if (count_q != '0) begin
									count_d = count_q - CW'(1);
									kill_d  = 1'b0;
									if (lflags_q[2]) begin
										mreq.re    = 1'b1;
										mreq.raddr = ADDR_MAX_W'(count_q - CW'(1));
									end
								end
							end else if (is_kill) begin
								if (!lflags_q[2] || !lflags_q[5]) count_d = '0;
								echo_c_d = kill_c;
								cont_d   = lflags_q[4] ? CONT_KNL : CONT_DONE;
							end else if (is_eofc) begin
								eof_d = 1'b1;
							end else begin
								echo_c_d = c_q;
								cont_d   = CONT_STORE;
							end
						end else begin
							echo_c_d = c_q;
							cont_d   = CONT_RAW;
						end
					end
					default: begin
					end
				endcase
			end
			ST_ECHO: begin
				priority if (e_nl) begin
					emit_v = 1'b1;
					emit_r = mk_res(KIND_ECHO, echo_c_q, 16'd1, '0, '0, 1'b0);
					col_d  = '0;
					mod_d  = '0;
				end else if (e_tab) begin
					emit_v = 1'b1;
					if (oflags_q[2]) begin
						emit_r = mk_res(KIND_ECHO, CH_SP,
							16'(DW'(TAB_WIDTH) - DW'(mod_q)), '0, '0, 1'b0);
					end else begin
						emit_r = mk_res(KIND_ECHO, CH_TAB, 16'd1, '0, '0, 1'b0);
					end
					{col_d, mod_d} = col_add(col_q, mod_q, DW'(TAB_WIDTH) - DW'(mod_q));
				end else if (e_bs) begin
					if (col_q != '0) begin
						emit_v = 1'b1;
						emit_r = mk_res(KIND_ECHO, CH_BS, 16'd1, '0, '0, 1'b0);
						{col_d, mod_d} = col_sub(col_q, mod_q, 2'd1);
					end
				end else if (e_caret) begin
					emit_v = 1'b1;
					emit_r = mk_res(KIND_ECHO, CH_CARET, 16'd1, '0, '0, 1'b0);
				end else begin
					emit_v = 1'b1;
					emit_r = mk_res(KIND_ECHO, echo_c_q, 16'd1, '0, '0, 1'b0);
					{col_d, mod_d} = col_add(col_q, mod_q, DW'(1));
				end
			end
			ST_ECHO2: begin
				emit_v = 1'b1;
				emit_r = mk_res(KIND_ECHO, (echo_c_q == CH_DEL) ? CH_QMARK : echo_c_q + CH_AT,
					16'd1, '0, '0, 1'b0);
				{col_d, mod_d} = col_add(col_q, mod_q, DW'(2));
			end
			ST_KNL: begin
				emit_v = 1'b1;
				emit_r = mk_res(KIND_ECHO, CH_NL, 16'd1, '0, '0, 1'b0);
				col_d  = '0;
				mod_d  = '0;
			end
			ST_RAW: begin
				emit_v = 1'b1;
				emit_r = mk_res(KIND_RAW, c_q, '0, '0, '0, 1'b0);
			end
			ST_TX2: begin
				emit_v = 1'b1;
				emit_r = mk_res(KIND_TX, c_q, '0, '0, '0, 1'b0);
			end
			ST_STORE: begin
				if (count_q < CW'(LINE_CAP - 1)) begin
					mreq.we    = 1'b1;
					mreq.waddr = ADDR_MAX_W'(count_q);
					mreq.wdata = c_q;
					count_d    = count_q + CW'(1);
				end
				eof_d = 1'b0;
			end
			ST_DLV_START, ST_TABW_START: begin
				idx_d = '0;
				nc_d  = '0;
				ncm_d = '0;
				if (count_q != '0) begin
					mreq.re    = 1'b1;
					mreq.raddr = '0;
				end
			end
			ST_DLV: begin
				emit_v = 1'b1;
				emit_r = mk_res(KIND_LINE, rdata, '0, '0, '0, 1'b0);
				if (!idx_end) begin
					mreq.re    = 1'b1;
					mreq.raddr = ADDR_MAX_W'(idx_q + CW'(1));
					idx_d      = idx_q + CW'(1);
				end
			end
			ST_DLV_END: begin
				emit_v  = 1'b1;
				emit_r  = mk_res(KIND_LEND, '0, '0, '0, 5'(count_q), eof_q);
				count_d = '0;
			end
			ST_ERASE: begin
				if (rdata != CH_TAB && erase_w != 2'd0) begin
					emit_v = 1'b1;
					emit_r = mk_res(KIND_ERASE, '0, 16'(erase_w), '0, '0, 1'b0);
					{col_d, mod_d} = col_sub(col_q, mod_q, erase_w);
				end
			end
			ST_TABW: begin
				priority if (rdata == CH_TAB) begin
					{nc_d, ncm_d} = col_add(nc_q, ncm_q, DW'(TAB_WIDTH) - DW'(ncm_q));
				end else if (is_ctrl(rdata)) begin
					{nc_d, ncm_d} = col_add(nc_q, ncm_q, lflags_q[3] ? DW'(2) : DW'(0));
				end else begin
					{nc_d, ncm_d} = col_add(nc_q, ncm_q, DW'(1));
				end
				if (!idx_end) begin
					mreq.re    = 1'b1;
					mreq.raddr = ADDR_MAX_W'(idx_q + CW'(1));
					idx_d      = idx_q + CW'(1);
				end
			end
			ST_TABW_END: begin
				if (col_q > nc_q) begin
					emit_v = 1'b1;
					emit_r = mk_res(KIND_ERASE, '0, col_q - nc_q, '0, '0, 1'b0);
					col_d  = nc_q;
					mod_d  = ncm_q;
				end
			end
			ST_KILL: begin
				if (count_q != '0) begin
					count_d    = count_q - CW'(1);
					kill_d     = 1'b1;
					mreq.re    = 1'b1;
					mreq.raddr = ADDR_MAX_W'(count_q - CW'(1));
				end
			end
			default: begin
			end
		endcase
		// A stalled step must leave the store untouched so it can repeat.
		if (stall) begin
			mreq = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			col_q      <= '0;
			mod_q      <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			iflags_q   <= IFLAGS_RST;
			lflags_q   <= LFLAGS_RST;
			oflags_q   <= OFLAGS_RST;
			sigch_q    <= SIGCH_RST;
			editch_q   <= EDITCH_RST;
			cont_q     <= CONT_DONE;
			kill_q     <= 1'b0;
			eof_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_INPUT_FLAGS:  iflags_q <= cfg_data[2:0];
					CFG_LOCAL_FLAGS:  lflags_q <= cfg_data[6:0];
					CFG_OUTPUT_FLAGS: oflags_q <= cfg_data[2:0];
					CFG_SIGNAL_CHARS: sigch_q  <= cfg_data[23:0];
					CFG_EDIT_CHARS:   editch_q <= cfg_data;
					default: begin
					end
				endcase
			end
			state_q <= state_d;
			if (!stall) begin
				count_q <= count_d;
				col_q   <= col_d;
				mod_q   <= mod_d;
				cont_q  <= cont_d;
				kill_q  <= kill_d;
				eof_q   <= eof_d;
				if (emit_v) begin
					pend_v_q <= 1'b1;
				end else if (fin_push) begin
					pend_v_q <= 1'b0;
				end
			end
			if (!stall && need_out) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q <= s_tuser;
			c_q   <= map_c;
			ign_q <= map_ign;
		end
		if (!stall) begin
			echo_c_q <= echo_c_d;
			idx_q    <= idx_d;
			nc_q     <= nc_d;
			ncm_q    <= ncm_d;
			if (emit_v) pend_q <= emit_r;
			if (need_out) begin
				out_q      <= pend_q;
				out_last_q <= fin_push;
			end
		end
	end

	// No item is taken while a staged result of the previous one is still held.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("staged result left over at idle");

	// A line walk only reads entries below the line count.
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DLV || state_q == ST_TABW) |-> (idx_q < count_q))
		else $error("line walk beyond line count");

	// A stall freezes the sequencer and the line count.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (state_q == $past(state_q)) && (count_q == $past(count_q)))
		else $error("sequencer moved during a stall");

endmodule
